@@ design/actr_pkg.sv @@
// ----------------------------------------------------------------------------
// actr_pkg: shared types and AES helpers
// Request/response payloads, queue entry, S-box and round functions.
// ----------------------------------------------------------------------------
`default_nettype none
package actr_pkg;

   localparam int unsigned COUNT_WIDTH = 7;
   localparam int unsigned DATA_WIDTH  = 64;
   localparam int unsigned VB_WIDTH    = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_LOW  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_HIGH = 1'b1;

   typedef enum logic {
      ACTION_DRAW    = 1'b0,
      ACTION_RESTART = 1'b1
   } action_type;

   typedef struct packed {
      logic                   action;
      logic [COUNT_WIDTH-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data;
      logic [VB_WIDTH-1:0]   valid_bytes;
      logic                  last;
   } rsp_type;

   // Classified command passed from front to back.
   typedef struct packed {
      logic                   restart;
      logic [COUNT_WIDTH-1:0] count;   // 0 means acknowledge only
   } cmd_type;

   typedef enum logic [2:0] {
      ST_KEY,      // expanding round keys
      ST_ENC,      // running cipher rounds
      ST_IDLE,     // waiting for a command
      ST_EMIT      // producing result words
   } back_state_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the state sits in bits 8*i+7:8*i.
   function automatic logic [127:0] aes_round(input logic [127:0] s,
                                              input logic [127:0] rk,
                                              input logic         final_round);
      logic [127:0] t;
      logic [127:0] m;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(c*4+r) +: 8] = sbox(s[8*((((c + r) % 4) * 4) + r) +: 8]);
         end
      end
      m = t;
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(c*4) +: 8];
         a1 = t[8*(c*4+1) +: 8];
         a2 = t[8*(c*4+2) +: 8];
         a3 = t[8*(c*4+3) +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[8*(c*4) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
         m[8*(c*4+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         m[8*(c*4+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         m[8*(c*4+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return (final_round ? t : m) ^ rk;
   endfunction

   function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                   input logic [7:0]   rc);
      logic [31:0]  w0, w1, w2, w3, t;
      w0 = k[31:0];
      w1 = k[63:32];
      w2 = k[95:64];
      w3 = k[127:96];
      t = {sbox(w3[7:0]), sbox(w3[31:24]), sbox(w3[23:16]),
           sbox(w3[15:8]) ^ rc};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w3, w2, w1, w0};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] i);
      logic [7:0] r;
      case (i)
         4'd1:    r = 8'h01;
         4'd2:    r = 8'h02;
         4'd3:    r = 8'h04;
         4'd4:    r = 8'h08;
         4'd5:    r = 8'h10;
         4'd6:    r = 8'h20;
         4'd7:    r = 8'h40;
         4'd8:    r = 8'h80;
         4'd9:    r = 8'h1b;
         4'd10:   r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/actr_front.sv @@
// ----------------------------------------------------------------------------
// actr_front: request intake
// Accepts requests, saturates draw sizes and pushes commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_front #(
   parameter int unsigned CAP = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  actr_pkg::req_type    req_payload,
   output logic                 push,
   output actr_pkg::cmd_type    push_cmd,
   input  wire                  full
);
   logic [actr_pkg::COUNT_WIDTH-1:0] cap_count;

   assign cap_count = actr_pkg::COUNT_WIDTH'(CAP);
   assign req_ready = !full;
   assign push      = req_valid && !full;

   always_comb begin
      push_cmd.restart = (req_payload.action == actr_pkg::ACTION_RESTART);
      if (push_cmd.restart) begin
         push_cmd.count = '0;
      end else if (req_payload.byte_count > cap_count) begin
         push_cmd.count = cap_count;
      end else begin
         push_cmd.count = req_payload.byte_count;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> push_cmd.count <= cap_count)
      else $error("command count above cap");
   assert property (@(posedge clock) disable iff (reset)
      push && push_cmd.restart |-> push_cmd.count == '0)
      else $error("restart carries a count");
   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");
endmodule
`default_nettype wire

@@ design/actr_queue.sv @@
// ----------------------------------------------------------------------------
// actr_queue: command queue
// Two-entry queue that decouples intake from the cipher back end.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  actr_pkg::cmd_type  push_cmd,
   output logic               full,
   output logic               not_empty,
   input  wire                pop,
   output actr_pkg::cmd_type  head
);
   actr_pkg::cmd_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count lost a push");
endmodule
`default_nettype wire

@@ design/actr_back.sv @@
// ----------------------------------------------------------------------------
// actr_back: keystream engine
// Expands keys and encrypts counter blocks one round a cycle, and packs
// stream bytes one per cycle into result words, pausing on a full word.
// ----------------------------------------------------------------------------
`default_nettype none
module actr_back (
   input  wire                clock,
   input  wire                reset,
   input  wire [127:0]        seed,
   input  wire                cmd_avail,
   input  actr_pkg::cmd_type  cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output actr_pkg::rsp_type  rsp_payload
);
   localparam logic [3:0] LAST_ROUND = 4'd10;

   actr_pkg::back_state_type state_ff, state_in;
   logic [127:0] rk_ff [11];
   logic [3:0]   round_ff, round_in;
   logic [127:0] blk_ff, blk_in;
   logic [63:0]  ctr_ff, ctr_in;
   logic [3:0]   pos_ff, pos_in;
   logic [6:0]   left_ff, left_in;
   logic [3:0]   wcnt_ff, wcnt_in;
   logic [63:0]  word_ff, word_in;
   logic         rv_ff, rv_in;
   actr_pkg::rsp_type out_ff, out_in;
   logic         key_load, resume_emit_ff, resume_emit_in;
   logic         take_byte, room;

   assign rsp_valid   = rv_ff;
   assign rsp_payload = out_ff;
   assign room        = !rv_ff || rsp_ready;
   assign take_byte   = (state_ff == actr_pkg::ST_EMIT) && (left_ff != '0)
                        && (wcnt_ff != 4'd8);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         actr_pkg::ST_KEY: begin
            if (round_ff == LAST_ROUND) state_in = actr_pkg::ST_ENC;
         end
         actr_pkg::ST_ENC: begin
            if (round_ff == LAST_ROUND) begin
               state_in = resume_emit_ff ? actr_pkg::ST_EMIT : actr_pkg::ST_IDLE;
            end
         end
         actr_pkg::ST_IDLE: begin
            if (cmd_avail && room) begin
               if (cmd.restart) state_in = actr_pkg::ST_KEY;
               else if (cmd.count != '0) state_in = actr_pkg::ST_EMIT;
            end
         end
         actr_pkg::ST_EMIT: begin
            if (take_byte && pos_ff == 4'd15) state_in = actr_pkg::ST_ENC;
            else if (left_ff == '0 && wcnt_ff == '0) state_in = actr_pkg::ST_IDLE;
         end
         default: state_in = actr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      round_in = round_ff;
      blk_in   = blk_ff;
      ctr_in   = ctr_ff;
      pos_in   = pos_ff;
      left_in  = left_ff;
      wcnt_in  = wcnt_ff;
      word_in  = word_ff;
      rv_in    = rv_ff && !rsp_ready;
      out_in   = out_ff;
      pop      = 1'b0;
      key_load = 1'b0;
      resume_emit_in = resume_emit_ff;
      unique case (state_ff)
         actr_pkg::ST_KEY: begin
            round_in = (round_ff == LAST_ROUND) ? 4'd0 : round_ff + 4'd1;
            if (round_ff == LAST_ROUND) begin
               blk_in = {64'd0, ctr_ff} ^ rk_ff[0];
               round_in = 4'd1;
            end
         end
         actr_pkg::ST_ENC: begin
            blk_in   = actr_pkg::aes_round(blk_ff, rk_ff[round_ff],
                                           round_ff == LAST_ROUND);
            round_in = round_ff + 4'd1;
         end
         actr_pkg::ST_IDLE: begin
            if (cmd_avail && room) begin
               pop = 1'b1;
               if (cmd.restart) begin
                  key_load = 1'b1;
                  round_in = 4'd1;
                  ctr_in   = '0;
                  pos_in   = '0;
                  resume_emit_in = 1'b0;
               end
               if (cmd.restart || cmd.count == '0) begin
                  rv_in  = 1'b1;
                  out_in = '{data: '0, valid_bytes: '0, last: 1'b1};
               end else begin
                  left_in = cmd.count;
                  wcnt_in = '0;
                  word_in = '0;
               end
            end
         end
         actr_pkg::ST_EMIT: begin
            if (take_byte) begin
               word_in[8*wcnt_ff[2:0] +: 8] = blk_ff[8*pos_ff +: 8];
               wcnt_in = wcnt_ff + 4'd1;
               left_in = left_ff - 7'd1;
               pos_in  = pos_ff + 4'd1;
               if (pos_ff == 4'd15) begin
                  ctr_in   = ctr_ff + 64'd1;
                  blk_in   = {64'd0, ctr_ff + 64'd1} ^ rk_ff[0];
                  round_in = 4'd1;
                  resume_emit_in = 1'b1;
               end
            end else if (wcnt_ff != '0 && room) begin
               rv_in   = 1'b1;
               out_in  = '{data: word_ff, valid_bytes: wcnt_ff,
                           last: (left_ff == '0)};
               wcnt_in = '0;
               word_in = '0;
            end
         end
         default: ;
      endcase
      if (state_ff == actr_pkg::ST_ENC && round_ff == LAST_ROUND) begin
         round_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= actr_pkg::ST_KEY;
         round_ff <= 4'd1;
         ctr_ff   <= '0;
         pos_ff   <= '0;
         left_ff  <= '0;
         wcnt_ff  <= '0;
         rv_ff    <= 1'b0;
         resume_emit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         ctr_ff   <= ctr_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         wcnt_ff  <= wcnt_in;
         rv_ff    <= rv_in;
         resume_emit_ff <= resume_emit_in;
      end
      blk_ff  <= blk_in;
      word_ff <= word_in;
      out_ff  <= out_in;
      // round key schedule: key 0 loads from seed, then one key per cycle
      if (reset || key_load) begin
         rk_ff[0] <= reset ? 128'd0 : seed;
      end else if (state_ff == actr_pkg::ST_KEY) begin
         rk_ff[round_ff] <= actr_pkg::next_round_key(rk_ff[round_ff - 4'd1],
                                                     actr_pkg::rcon(round_ff));
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(out_ff))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == actr_pkg::ST_IDLE)
      else $error("command taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      take_byte |-> wcnt_ff < 4'd8)
      else $error("result word overfilled");
endmodule
`default_nettype wire

@@ design/aes_ctr_byte_generator_top.sv @@
// ----------------------------------------------------------------------------
// aes_ctr_byte_generator_top: AES-128 counter-mode byte generator
// Front end classifies requests into a command queue; the back end runs the
// key schedule and cipher rounds and packs stream bytes into result words.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid/req_ready    actr_pkg::req_type
//  rsp       out        rsp_valid/rsp_ready    actr_pkg::rsp_type
//  csr       in         csr_write_enable       csr_index, csr_write_data
//
// Draws: the back end packs stream bytes one per cycle into a result word
// until the word is full or the draw ends, and sends the word once the
// output register is free; after every 16 bytes it stops while the round
// unit encrypts the next counter block. A restart reloads the seed, expands
// the round keys and encrypts block 0 before the next command is taken.
// Reset: round keys expand from a zero seed and block 0 is encrypted before
// the first command is served. Stalls: rsp_ready low holds the back end; the
// two-entry queue keeps req_ready high until it fills.
`default_nettype none
module aes_ctr_byte_generator_top #(
   parameter int unsigned MAX_REQUEST_BYTES = 64
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  actr_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output actr_pkg::rsp_type    rsp_payload,
   input  wire                  csr_write_enable,
   input  wire [actr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire [63:0]           csr_write_data
);
   // Draws saturate to the smaller of the parameter and eight full words.
   localparam int unsigned CAP = (MAX_REQUEST_BYTES < 64) ? MAX_REQUEST_BYTES : 64;

   logic [63:0]       seed_low_ff, seed_high_ff;
   logic              push, full, not_empty, pop;
   actr_pkg::cmd_type push_cmd, head;

   // Seed registers: take effect at the next restart.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_low_ff  <= '0;
         seed_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            actr_pkg::CSR_SEED_LOW:  seed_low_ff  <= csr_write_data;
            actr_pkg::CSR_SEED_HIGH: seed_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   actr_front #(.CAP(CAP)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .push, .push_cmd, .full
   );

   actr_queue u_queue (
      .clock, .reset, .push, .push_cmd, .full, .not_empty, .pop, .head
   );

   actr_back u_back (
      .clock, .reset,
      .seed({seed_high_ff, seed_low_ff}),
      .cmd_avail(not_empty), .cmd(head), .pop,
      .rsp_valid, .rsp_ready, .rsp_payload
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.valid_bytes == '0 |-> rsp_payload.last)
      else $error("empty result without last");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.valid_bytes <= 4'd8)
      else $error("result byte count out of range");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> push)
      else $error("accepted request not queued");
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: AES-128 counter-mode byte generator testbench
// Drives draw and restart requests over the valid/ready channels, rewrites
// the seed registers between phases, and checks every result word against a
// local AES-CTR keystream predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned MAX_BYTES   = 64;
   localparam int unsigned DRAIN_WAIT  = 60;   // restart plus one block of rounds, padded

   // Forward S-box, kept locally for the keystream predictor.
   localparam logic [7:0] SUB_BYTE [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] ROUND_CONST [11] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   actr_pkg::req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   actr_pkg::rsp_type rsp_payload;
   logic        csr_write_enable;
   logic [actr_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [63:0] csr_write_data;

   aes_ctr_byte_generator_top #(
      .MAX_REQUEST_BYTES(MAX_BYTES)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ------------------------------------------------------------------
   // Keystream predictor state: seed registers as written, the key in
   // force since the last restart, and the position in the stream.
   // ------------------------------------------------------------------
   logic [63:0]  seed_low_reg;
   logic [63:0]  seed_high_reg;
   logic [7:0]   key_bytes [176];    // expanded schedule, byte by byte
   logic [63:0]  stream_block_index;
   logic [7:0]   stream_block [16];
   int unsigned  stream_offset;

   actr_pkg::rsp_type pending_words [$];  // result words still owed by the block
   int unsigned  mismatch_count;
   int unsigned  sender_idle_pct;
   int unsigned  receiver_stall_pct;

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Expand the seed registers into all eleven round keys.
   task automatic load_key_schedule();
      logic [7:0] t [4];
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         key_bytes[i]     = seed_low_reg[8*i +: 8];
         key_bytes[8 + i] = seed_high_reg[8*i +: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int k = 0; k < 4; k++) t[k] = key_bytes[4*(i-1) + k];
         if (i % 4 == 0) begin
            r    = t[0];
            t[0] = SUB_BYTE[t[1]] ^ ROUND_CONST[i/4];
            t[1] = SUB_BYTE[t[2]];
            t[2] = SUB_BYTE[t[3]];
            t[3] = SUB_BYTE[r];
         end
         for (int k = 0; k < 4; k++) key_bytes[4*i + k] = key_bytes[4*(i-4) + k] ^ t[k];
      end
   endtask

   // Encrypt the counter block for the current block index.
   task automatic encrypt_block();
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      for (int i = 0; i < 16; i++)
         s[i] = ((i < 8) ? stream_block_index[8*i +: 8] : 8'h00) ^ key_bytes[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[c*4 + r] = SUB_BYTE[s[((c + r) % 4)*4 + r]];
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               t[c*4]   = a0 ^ all ^ gf_double(a0 ^ a1);
               t[c*4+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               t[c*4+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               t[c*4+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ key_bytes[16*rnd + i];
      end
      for (int i = 0; i < 16; i++) stream_block[i] = s[i];
   endtask

   task automatic restart_stream();
      load_key_schedule();
      stream_block_index = '0;
      stream_offset      = 0;
      encrypt_block();
   endtask

   // Take the next keystream byte; on exhaustion bump the counter (wraps).
   task automatic take_stream_byte(output logic [7:0] b);
      b = stream_block[stream_offset];
      stream_offset++;
      if (stream_offset >= 16) begin
         stream_block_index++;
         stream_offset = 0;
         encrypt_block();
      end
   endtask

   // Work out the result words of one accepted request.
   task automatic predict_request(input actr_pkg::req_type r);
      int unsigned n;
      int unsigned words;
      int unsigned cnt;
      actr_pkg::rsp_type w;
      logic [7:0]  b;
      n = r.byte_count;
      if (r.action == actr_pkg::ACTION_RESTART || n == 0) begin
         if (r.action == actr_pkg::ACTION_RESTART) restart_stream();
         w = '0;
         w.last = 1'b1;
         pending_words.push_back(w);
      end else begin
         if (n > MAX_BYTES) n = MAX_BYTES;
         words = (n + 7) / 8;
         for (int k = 0; k < words; k++) begin
            cnt = n - 8*k;
            if (cnt > 8) cnt = 8;
            w = '0;
            for (int j = 0; j < cnt; j++) begin
               take_stream_byte(b);
               w.data[8*j +: 8] = b;
            end
            w.valid_bytes = 4'(cnt);
            w.last        = (k + 1 == words);
            pending_words.push_back(w);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $realtime, what);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Result checker: compare each transfer with the oldest expected word.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      actr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_payload));
         end else begin
            want = pending_words.pop_front();
            if (rsp_payload.data !== want.data)
               report_mismatch($sformatf("data %h, want %h", rsp_payload.data, want.data));
            if (rsp_payload.valid_bytes !== want.valid_bytes)
               report_mismatch($sformatf("valid_bytes %0d, want %0d",
                                         rsp_payload.valid_bytes, want.valid_bytes));
            if (rsp_payload.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_payload.last, want.last));
         end
      end
   end

   // Receiver back-pressure: stall at the phase's rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Send one request; predict at the edge that completes the transfer.
   task automatic send_request(input actr_pkg::action_type act, input logic [6:0] count);
      actr_pkg::req_type r;
      r.action     = act;
      r.byte_count = count;
      // optional idle cycles with valid dropped
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_request(r);
   endtask

   // Drop valid, let every owed word drain, then give the round unit time.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write one seed register while idle; the key applies at the next restart.
   task automatic write_seed(input logic [actr_pkg::CSR_INDEX_WIDTH-1:0] idx,
                             input logic [63:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == actr_pkg::CSR_SEED_LOW) seed_low_reg = v;
      else                               seed_high_reg = v;
   endtask

   task automatic set_seed(input logic [63:0] lo, input logic [63:0] hi);
      wait_idle();
      write_seed(actr_pkg::CSR_SEED_LOW, lo);
      write_seed(actr_pkg::CSR_SEED_HIGH, hi);
   endtask

   function automatic logic [6:0] random_count();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4)  return 7'd0;
      if (pick < 10) return 7'($urandom_range(127, 65));
      if (pick < 20) return 7'(8 * $urandom_range(8, 1));
      return 7'($urandom_range(64, 1));
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Stream straight out of reset under the zero seed, crossing blocks.
   task automatic test_reset_stream();
      send_request(actr_pkg::ACTION_DRAW, 7'd1);
      send_request(actr_pkg::ACTION_DRAW, 7'd8);
      send_request(actr_pkg::ACTION_DRAW, 7'd9);    // ends a block, spills into the next
      send_request(actr_pkg::ACTION_DRAW, 7'd16);
      send_request(actr_pkg::ACTION_DRAW, 7'd64);
   endtask

   // Edge counts and restart handling.
   task automatic test_edge_requests();
      send_request(actr_pkg::ACTION_DRAW, 7'd0);    // ack only, stream holds
      send_request(actr_pkg::ACTION_DRAW, 7'd7);
      send_request(actr_pkg::ACTION_DRAW, 7'd65);   // clamps to 64
      send_request(actr_pkg::ACTION_DRAW, 7'd127);
      send_request(actr_pkg::ACTION_RESTART, 7'd0);
      send_request(actr_pkg::ACTION_DRAW, 7'd15);
      send_request(actr_pkg::ACTION_RESTART, 7'd127);  // count ignored on restart
      send_request(actr_pkg::ACTION_DRAW, 7'd17);
      send_request(actr_pkg::ACTION_DRAW, 7'd64);
   endtask

   // Seed extremes: a write alone must not change the stream.
   task automatic test_seed_extremes();
      set_seed('1, '1);
      send_request(actr_pkg::ACTION_DRAW, 7'd12);   // still the old key
      send_request(actr_pkg::ACTION_RESTART, 7'd0);
      send_request(actr_pkg::ACTION_DRAW, 7'd40);
      set_seed(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
      send_request(actr_pkg::ACTION_RESTART, 7'd0);
      send_request(actr_pkg::ACTION_DRAW, 7'd33);
      set_seed(64'h0, 64'hffff_ffff_ffff_ffff);
      send_request(actr_pkg::ACTION_RESTART, 7'd0);
      send_request(actr_pkg::ACTION_DRAW, 7'd64);
   endtask

   // Random traffic under one idling pattern, with a fresh random seed.
   task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned count);
      set_seed({$urandom, $urandom}, {$urandom, $urandom});
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      send_request(actr_pkg::ACTION_RESTART, 7'd0);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 6)
            send_request(actr_pkg::ACTION_RESTART, 7'($urandom_range(127)));
         else
            send_request(actr_pkg::ACTION_DRAW, random_count());
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = actr_pkg::CSR_SEED_LOW;
      csr_write_data   = '0;
      mismatch_count   = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      seed_low_reg     = '0;
      seed_high_reg    = '0;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_stream();
      test_edge_requests();
      test_seed_extremes();
      test_random_phase(10, 75, 150);
      test_random_phase(75, 10, 150);
      test_random_phase(0, 0, 150);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("aes_ctr_byte_generator_top test passed");
      end else begin
         $display("aes_ctr_byte_generator_top test failed");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20ms;
      $display("aes_ctr_byte_generator_top test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
design/actr_pkg.sv
design/actr_front.sv
design/actr_queue.sv
design/actr_back.sv
design/aes_ctr_byte_generator_top.sv
dv/tb_top.sv
